// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the core RTL.
// Every macro samples on clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant checked at every clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/nfha_pkg.sv =====
// Package for the next-fit hole allocator: sizes, codes and cell control word.
// No dependencies.
package nfha_pkg;

   localparam int MAX_HOLES = 16;
   localparam int ADDR_BITS = 16;
   localparam int IDX_BITS  = $clog2(MAX_HOLES);
   localparam int CNT_BITS  = $clog2(MAX_HOLES + 1);

   localparam logic REQ_ADD   = 1'b0;
   localparam logic REQ_ALLOC = 1'b1;

   localparam logic [1:0] ST_ALLOCATED = 2'd0;
   localparam logic [1:0] ST_NO_FIT    = 2'd1;
   localparam logic [1:0] ST_STORED    = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic seed;     // place the scan token at the selected cell
      logic advance;  // move the token one cell along the ring
      logic commit;   // apply the grant: trim or remove the hit hole
      logic load;     // write a new hole into the selected cell
   } cell_ctl_type;

endpackage

// ===== rtl/core/nfha_if.sv =====
// Valid/ready channel interfaces for the request and response words.
// Depends on nfha_pkg.
interface nfha_req_if;
   logic                           valid;
   logic                           ready;
   logic                           req_type;
   logic [nfha_pkg::ADDR_BITS-1:0] region_base;
   logic [nfha_pkg::ADDR_BITS-1:0] region_size;

   modport source (output valid, req_type, region_base, region_size, input ready);
   modport sink   (input valid, req_type, region_base, region_size, output ready);
endinterface

interface nfha_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     status;
   logic [nfha_pkg::ADDR_BITS-1:0] granted_base;

   modport source (output valid, status, granted_base, input ready);
   modport sink   (input valid, status, granted_base, output ready);
endinterface

// ===== rtl/core/next_fit_hole_allocator.sv =====
// Channel | Dir | Word fields
// --------+-----+------------------------------------------
// req     | in  | req_type[0], region_base[15:0], region_size[15:0]
// rsp     | out | status[1:0], granted_base[15:0]
// Add: registered on acceptance, then S_ADD answers, storing a nonzero hole if
// there is room. Allocate: the scan token is seeded at the pointer cell, then
// S_SCAN steps it one cell along the ring, up to count_ff holes; a miss answers from S_MISS.
// One request is in flight at a time; the response register frees req side.
// A stalled rsp holds the final step. Synchronous reset empties the table.
// Depends on nfha_pkg, nfha_if, nfha_row, nfha_cell, assert_macros.svh.
`include "assert_macros.svh"

module next_fit_hole_allocator (
   input  logic       clock,
   input  logic       reset,
   nfha_req_if.sink   req,
   nfha_rsp_if.source rsp
);

   typedef enum logic [1:0] {S_IDLE, S_ADD, S_SCAN, S_MISS} state_type;

   state_type                       state_ff, state_in;
   logic [nfha_pkg::CNT_BITS-1:0]   count_ff, count_in;
   logic [nfha_pkg::IDX_BITS-1:0]   ptr_ff, ptr_in;
   logic [nfha_pkg::IDX_BITS-1:0]   pos_ff, pos_in;
   logic [nfha_pkg::IDX_BITS-1:0]   step_ff, step_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [1:0]                      rsp_status_ff, rsp_status_in;
   logic [nfha_pkg::ADDR_BITS-1:0]  rsp_base_ff, rsp_base_in;
   logic                            kind_ff, kind_in;
   logic [nfha_pkg::ADDR_BITS-1:0]  base_ff, base_in;
   logic [nfha_pkg::ADDR_BITS-1:0]  size_ff, size_in;

   nfha_pkg::cell_ctl_type          ctl;
   logic [nfha_pkg::MAX_HOLES-1:0]  sel;
   logic [nfha_pkg::MAX_HOLES-1:0]  last;
   logic [nfha_pkg::IDX_BITS-1:0]   sel_idx;
   logic [nfha_pkg::CNT_BITS-1:0]   cnt_m1;
   logic                            hit;
   logic                            exact;
   logic [nfha_pkg::ADDR_BITS-1:0]  grant_base;
   logic                            out_free;
   logic                            accept;

   nfha_row u_row (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sel        (sel),
      .last       (last),
      .wr_base    (base_ff),
      .wr_size    (size_ff),
      .req_size   (size_ff),
      .hit        (hit),
      .exact      (exact),
      .grant_base (grant_base)
   );

   assign req.ready        = (state_ff == S_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.granted_base = rsp_base_ff;

   always_comb begin
      accept   = req.valid && req.ready;
      out_free = !rsp_valid_ff || rsp.ready;
      cnt_m1   = count_ff - nfha_pkg::CNT_BITS'(1);
      sel_idx  = (state_ff == S_IDLE) ? ptr_ff : count_ff[nfha_pkg::IDX_BITS-1:0];
      for (int i = 0; i < nfha_pkg::MAX_HOLES; i++) begin
         sel[i]  = (sel_idx == nfha_pkg::IDX_BITS'(i));
         last[i] = (cnt_m1[nfha_pkg::IDX_BITS-1:0] == nfha_pkg::IDX_BITS'(i));
      end

      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      pos_in        = pos_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_base_in   = rsp_base_ff;
      kind_in       = kind_ff;
      base_in       = base_ff;
      size_in       = size_ff;
      ctl           = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in = req.req_type;
               base_in = req.region_base;
               size_in = req.region_size;
               if (req.req_type == nfha_pkg::REQ_ADD) begin
                  state_in = S_ADD;
               end else if (count_ff == '0) begin
                  state_in = S_MISS;
               end else begin
                  ctl.seed = 1'b1;
                  pos_in   = ptr_ff;
                  step_in  = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_ADD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_base_in  = '0;
               state_in     = S_IDLE;
               if (size_ff == '0) begin
                  rsp_status_in = nfha_pkg::ST_STORED;
               end else if (count_ff == nfha_pkg::CNT_BITS'(nfha_pkg::MAX_HOLES)) begin
                  rsp_status_in = nfha_pkg::ST_FULL;
               end else begin
                  ctl.load      = 1'b1;
                  count_in      = count_ff + nfha_pkg::CNT_BITS'(1);
                  rsp_status_in = nfha_pkg::ST_STORED;
               end
            end
         end
         S_SCAN: begin
            if (hit) begin
               if (out_free) begin
                  ctl.commit    = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = nfha_pkg::ST_ALLOCATED;
                  rsp_base_in   = grant_base;
                  state_in      = S_IDLE;
                  if (exact) begin
                     count_in = cnt_m1;
                     // removing the last entry wraps the pointer
                     ptr_in   = ({1'b0, pos_ff} < cnt_m1) ? pos_ff : '0;
                  end else begin
                     ptr_in = pos_ff;
                  end
               end
            end else if ({1'b0, step_ff} == cnt_m1) begin
               state_in = S_MISS;
            end else begin
               ctl.advance = 1'b1;
               step_in     = step_ff + nfha_pkg::IDX_BITS'(1);
               pos_in      = ({1'b0, pos_ff} == cnt_m1) ? '0
                                                        : pos_ff + nfha_pkg::IDX_BITS'(1);
            end
         end
         S_MISS: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = nfha_pkg::ST_NO_FIT;
               rsp_base_in   = '0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      step_ff       <= step_in;
      rsp_status_ff <= rsp_status_in;
      rsp_base_ff   <= rsp_base_in;
      kind_ff       <= kind_in;
      base_ff       <= base_in;
      size_ff       <= size_in;
   end

   `ASSERT_ALWAYS(a_count_range, count_ff <= nfha_pkg::CNT_BITS'(nfha_pkg::MAX_HOLES), "hole count over capacity")
   `ASSERT_ALWAYS(a_ptr_range, (count_ff == '0 && ptr_ff == '0) || ({1'b0, ptr_ff} < count_ff), "scan pointer outside table")
   `ASSERT_IMPLY(a_scan_bounds, state_ff == S_SCAN, {1'b0, step_ff} < count_ff && kind_ff == nfha_pkg::REQ_ALLOC, "scan past table or on add")
   `ASSERT_NEXT(a_grant_word, state_ff == S_SCAN && hit && out_free, rsp_valid_ff && rsp_status_ff == nfha_pkg::ST_ALLOCATED, "grant not delivered")

endmodule

// ===== rtl/core/nfha_cell.sv =====
// One hole slot: base, size and scan token; trims, loads or takes its neighbor's hole.
// Depends on nfha_pkg.
module nfha_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  nfha_pkg::cell_ctl_type         ctl,
   input  logic                           sel,
   input  logic [nfha_pkg::ADDR_BITS-1:0] wr_base,
   input  logic [nfha_pkg::ADDR_BITS-1:0] wr_size,
   input  logic [nfha_pkg::ADDR_BITS-1:0] req_size,
   input  logic [nfha_pkg::ADDR_BITS-1:0] nb_base,
   input  logic [nfha_pkg::ADDR_BITS-1:0] nb_size,
   input  logic                           tok_prev,
   input  logic                           run_prev,
   output logic                           tok_out,
   output logic                           run_out,
   output logic                           hit,
   output logic                           exact,
   output logic [nfha_pkg::ADDR_BITS-1:0] base,
   output logic [nfha_pkg::ADDR_BITS-1:0] size
);

   logic [nfha_pkg::ADDR_BITS-1:0] base_ff, base_in;
   logic [nfha_pkg::ADDR_BITS-1:0] size_ff, size_in;
   logic                           tok_ff, tok_in;

   always_comb begin
      hit     = tok_ff && (size_ff >= req_size);
      exact   = tok_ff && (size_ff == req_size);
      run_out = run_prev | exact;
      tok_out = tok_ff;
      base    = base_ff;
      size    = size_ff;

      base_in = base_ff;
      size_in = size_ff;
      if (ctl.load && sel) begin
         base_in = wr_base;
         size_in = wr_size;
      end
      if (ctl.commit) begin
         if (run_out) begin
            // exact fit here or upstream: close the gap
            base_in = nb_base;
            size_in = nb_size;
         end else if (hit) begin
            base_in = base_ff + req_size;
            size_in = size_ff - req_size;
         end
      end

      tok_in = tok_ff;
      if (ctl.seed) begin
         tok_in = sel;
      end else if (ctl.advance) begin
         tok_in = tok_prev;
      end else if (ctl.commit) begin
         tok_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
      base_ff <= base_in;
      size_ff <= size_in;
   end

endmodule

// ===== rtl/core/nfha_row.sv =====
// Row of hole cells joined into a token ring and a shift-down chain.
// Depends on nfha_pkg and nfha_cell.
module nfha_row (
   input  logic                           clock,
   input  logic                           reset,
   input  nfha_pkg::cell_ctl_type         ctl,
   input  logic [nfha_pkg::MAX_HOLES-1:0] sel,
   input  logic [nfha_pkg::MAX_HOLES-1:0] last,
   input  logic [nfha_pkg::ADDR_BITS-1:0] wr_base,
   input  logic [nfha_pkg::ADDR_BITS-1:0] wr_size,
   input  logic [nfha_pkg::ADDR_BITS-1:0] req_size,
   output logic                           hit,
   output logic                           exact,
   output logic [nfha_pkg::ADDR_BITS-1:0] grant_base
);

   logic [nfha_pkg::MAX_HOLES-1:0] tok;
   logic [nfha_pkg::MAX_HOLES-1:0] run;
   logic [nfha_pkg::MAX_HOLES-1:0] hit_v;
   logic [nfha_pkg::MAX_HOLES-1:0] exact_v;
   logic [nfha_pkg::ADDR_BITS-1:0] base_v [nfha_pkg::MAX_HOLES];
   logic [nfha_pkg::ADDR_BITS-1:0] size_v [nfha_pkg::MAX_HOLES];
   logic                           tok_wrap;

   for (genvar g = 0; g < nfha_pkg::MAX_HOLES; g++) begin : g_cell
      logic                           tok_prev;
      logic                           run_prev;
      logic [nfha_pkg::ADDR_BITS-1:0] nb_base;
      logic [nfha_pkg::ADDR_BITS-1:0] nb_size;

      if (g == 0) begin : g_head
         assign tok_prev = tok_wrap;
         assign run_prev = 1'b0;
      end else begin : g_body
         assign tok_prev = tok[g-1] & ~last[g-1];
         assign run_prev = run[g-1];
      end

      if (g == nfha_pkg::MAX_HOLES - 1) begin : g_tail
         assign nb_base = '0;
         assign nb_size = '0;
      end else begin : g_next
         assign nb_base = base_v[g+1];
         assign nb_size = size_v[g+1];
      end

      nfha_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .sel      (sel[g]),
         .wr_base  (wr_base),
         .wr_size  (wr_size),
         .req_size (req_size),
         .nb_base  (nb_base),
         .nb_size  (nb_size),
         .tok_prev (tok_prev),
         .run_prev (run_prev),
         .tok_out  (tok[g]),
         .run_out  (run[g]),
         .hit      (hit_v[g]),
         .exact    (exact_v[g]),
         .base     (base_v[g]),
         .size     (size_v[g])
      );
   end

   always_comb begin
      tok_wrap   = |(tok & last);
      hit        = |hit_v;
      exact      = |exact_v;
      grant_base = '0;
      for (int i = 0; i < nfha_pkg::MAX_HOLES; i++) begin
         grant_base = grant_base | (base_v[i] & {nfha_pkg::ADDR_BITS{hit_v[i]}});
      end
   end

endmodule
